// ----- sv/fop_pkg.sv -----
// Shared constants and types for the forest out-of-bag proximity core.
// No dependencies; imported by forest_oob_proximity_core.
`default_nettype none

package fop_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int MAX_TREES   = 64;
    localparam int NODE_BITS   = 16;

    localparam int ENTRIES  = MAX_SAMPLES * MAX_TREES;
    localparam int ADDR_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(MAX_TREES + 1);
    localparam int ENTRY_W  = NODE_BITS + 1;

    // fixed field widths of the ports
    localparam int SAMPLE_W = 8;
    localparam int TREE_W   = 6;
    localparam int NODE_W   = 16;
    localparam int INBAG_W  = 8;
    localparam int PROX_W   = 17;
    localparam int COUNT_W  = 7;
    localparam int NS_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PROX_W-1:0] ONE_FIXED = PROX_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES = 1'b0,
        CFG_TREES   = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ----- sv/fop_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// Standalone; no package dependency.
`default_nettype none

module fop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- sv/forest_oob_proximity_core.sv -----
// Load: written to the entry store on acceptance, no result. Query: result register
// loaded after the tree reads, drain, 17 divider steps and output load; an index error
// goes straight to the output load. The next request is taken once the core is back
// in idle after the output load; a stalled result holds input.
// Reset (sync, active low) clears control and config (256 samples, 64 trees);
// the entry store is not cleared and has no clearing pass.
`default_nettype none

module forest_oob_proximity_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_cmd,
    input  wire logic [fop_pkg::SAMPLE_W-1:0]  i_sample_index,
    input  wire logic [fop_pkg::SAMPLE_W-1:0]  i_other_sample,
    input  wire logic [fop_pkg::TREE_W-1:0]    i_tree_index,
    input  wire logic [fop_pkg::NODE_W-1:0]    i_node_id,
    input  wire logic [fop_pkg::INBAG_W-1:0]   i_inbag_count,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [fop_pkg::PROX_W-1:0]         o_proximity,
    output logic [fop_pkg::COUNT_W-1:0]        o_shared_trees,
    output logic [fop_pkg::COUNT_W-1:0]        o_matching_trees,
    output logic                               o_index_error,
    // config write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fop_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fop_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import fop_pkg::*;

    localparam logic [NS_W-1:0]  NS_MAX = NS_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] NT_MAX = CNT_W'(MAX_TREES);

    t_state             r_state, n_state;
    logic [NS_W-1:0]    r_samples;
    logic [CNT_W-1:0]   r_trees;
    logic [ADDR_W-1:0]  r_addr_a, r_addr_b;
    logic [CNT_W-1:0]   r_tree;
    logic               r_rd_vld;
    logic [CNT_W-1:0]   r_shared, r_match;
    logic               r_same, r_err;
    logic [CNT_W:0]     r_rem;
    logic [PROX_W-1:0]  r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic               r_out_vld;

    logic               in_acc, out_acc, out_load;
    logic [NS_W-1:0]    ns_eff;
    logic [CNT_W-1:0]   nt_eff;
    logic               q_err;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata, rdata_a, rdata_b;
    logic               walk;
    logic [CNT_W:0]     rem_cur, trial;
    logic               ge;
    logic [PROX_W-1:0]  prox;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign out_acc     = r_out_vld && !i_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_vld || !i_stall);
    assign o_valid     = r_out_vld;

    assign ns_eff = (r_samples > NS_MAX) ? NS_MAX : r_samples;
    assign nt_eff = (r_trees > NT_MAX) ? NT_MAX : r_trees;
    assign q_err  = ({1'b0, i_sample_index} >= ns_eff) || ({1'b0, i_other_sample} >= ns_eff);

    // entry = {out_of_bag, node}
    assign we    = in_acc && (i_cmd == CMD_LOAD) &&
                   (32'(i_sample_index) < MAX_SAMPLES) && (32'(i_tree_index) < MAX_TREES);
    assign waddr = ADDR_W'(i_sample_index) * ADDR_W'(MAX_TREES) + ADDR_W'(i_tree_index);
    assign wdata = {(i_inbag_count == '0), NODE_BITS'(i_node_id)};
    assign walk  = (r_state == S_WALK);

    fop_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (walk),
        .i_raddr_a (r_addr_a),
        .i_raddr_b (r_addr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // restoring divider step: first step takes the final match count
    assign rem_cur = (r_div_cnt == '0) ? {1'b0, r_match} : r_rem;
    assign ge      = (rem_cur >= {1'b0, r_shared});
    assign trial   = rem_cur - {1'b0, r_shared};

    always_comb begin
        if (r_err) begin
            prox = '0;
        end else if (r_same) begin
            prox = ONE_FIXED;
        end else if (r_shared == '0) begin
            prox = '0;
        end else begin
            prox = r_quo;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_QUERY)) begin
                    if (q_err) begin
                        n_state = S_DONE;
                    end else if (nt_eff == '0) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_tree + CNT_W'(1) == nt_eff) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DIV;
            S_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_samples <= NS_W'(256);
            r_trees   <= CNT_W'(64);
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= walk;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SAMPLES: r_samples <= i_cfg_data[NS_W-1:0];
                    CFG_TREES:   r_trees   <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_cmd == CMD_QUERY)) begin
            r_addr_a  <= ADDR_W'(i_sample_index) * ADDR_W'(MAX_TREES);
            r_addr_b  <= ADDR_W'(i_other_sample) * ADDR_W'(MAX_TREES);
            r_tree    <= '0;
            r_shared  <= '0;
            r_match   <= '0;
            r_same    <= (i_sample_index == i_other_sample);
            r_err     <= q_err;
            r_div_cnt <= '0;
        end
        if (walk) begin
            r_addr_a <= r_addr_a + ADDR_W'(1);
            r_addr_b <= r_addr_b + ADDR_W'(1);
            r_tree   <= r_tree + CNT_W'(1);
        end
        if (r_rd_vld && rdata_a[ENTRY_W-1] && rdata_b[ENTRY_W-1]) begin
            r_shared <= r_shared + CNT_W'(1);
            if (rdata_a[NODE_BITS-1:0] == rdata_b[NODE_BITS-1:0]) begin
                r_match <= r_match + CNT_W'(1);
            end
        end
        if (r_state == S_DIV) begin
            r_rem     <= (ge ? trial : rem_cur) << 1;
            r_quo     <= {r_quo[PROX_W-2:0], ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (out_load) begin
            o_proximity      <= prox;
            o_shared_trees   <= r_err ? '0 : COUNT_W'(r_shared);
            o_matching_trees <= r_err ? '0 : COUNT_W'(r_match);
            o_index_error    <= r_err;
        end
    end

`ifndef NO_ASSERTIONS
    a_match_le_shared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && !r_err) |-> (r_match <= r_shared))
        else $error("matching count exceeds shared count");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_tree < nt_eff))
        else $error("tree walk past trees in use");

    a_div_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DIV) |-> $past(r_state == S_DRAIN))
        else $error("divider started without draining the walk");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_error) |->
        (o_proximity == '0 && o_shared_trees == '0 && o_matching_trees == '0))
        else $error("index error result carries nonzero fields");
`endif

endmodule

`default_nettype wire
